// ----- hw/rtl/int_key_hash_table_engine_defines.svh -----
// Assertion macros shared by the RTL of the integer-key hash table engine.
`ifndef INT_KEY_HASH_TABLE_ENGINE_DEFINES_SVH
`define INT_KEY_HASH_TABLE_ENGINE_DEFINES_SVH

// Checked on every clock edge while reset is released.
`define IKHT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IKHT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ikht_pkg.sv -----
`timescale 1ns / 1ps
package ikht_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FAIL      = 2'd2;

  // Bucket count register.
  localparam int         CFG_W        = 7;
  localparam logic [6:0] BUCKET_RESET = 7'd16;

  // Shift amounts of the one-at-a-time hash.
  localparam int HASH_SHL_ADD = 10;
  localparam int HASH_SHR_XOR = 6;
  localparam int FIN_SHL_A    = 3;
  localparam int FIN_SHR      = 11;
  localparam int FIN_SHL_B    = 15;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic [31:0]        entry_value;
    logic [31:0]        entry_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [31:0] found_size;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_RDHEAD,
    S_HEAD,
    S_POP,
    S_PULL,
    S_WALK,
    S_PUSH,
    S_DONE
  } state_e;

endpackage

// ----- hw/rtl/ikht_hash.sv -----
`timescale 1ns / 1ps
module ikht_hash (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              key_i,
  input  logic [ikht_pkg::CFG_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [ikht_pkg::CFG_W-1:0] bucket_o
);
  import ikht_pkg::*;

  // One key byte per step, one finishing step, then four quotient bits per step.
  localparam int         MOD_BITS  = 4;
  localparam logic [3:0] STEP_B0   = 4'd0;
  localparam logic [3:0] STEP_B3   = 4'd3;
  localparam logic [3:0] STEP_MIX  = 4'd4;
  localparam logic [3:0] STEP_LAST = 4'(5 + 32 / MOD_BITS - 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [3:0]        step_q, step_d;
  logic [31:0]       key_q, key_d;
  logic [31:0]       h_q, h_d;
  logic [CFG_W-1:0]  r_q, r_d;

  // Hash round, finishing mix and restoring remainder steps.
  always_comb begin
    logic [31:0]      t;
    logic [CFG_W:0]   w;
    logic [CFG_W-1:0] r;
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    key_d  = key_q;
    h_d    = h_q;
    r_d    = r_q;
    t      = h_q;
    w      = '0;
    r      = r_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = STEP_B0;
      key_d  = key_i;
      h_d    = '0;
      r_d    = '0;
    end else if (run_q) begin
      step_d = step_q + 4'd1;
      case (step_q) inside
        [STEP_B0:STEP_B3]: begin
          t     = h_q + {24'd0, key_q[7:0]};
          t     = t + (t << HASH_SHL_ADD);
          t     = t ^ (t >> HASH_SHR_XOR);
          h_d   = t;
          key_d = key_q >> 8;
        end
        STEP_MIX: begin
          t   = h_q + (h_q << FIN_SHL_A);
          t   = t ^ (t >> FIN_SHR);
          t   = t + (t << FIN_SHL_B);
          h_d = t;
        end
        default: begin
          for (int i = 0; i < MOD_BITS; i++) begin
            w = {r, h_q[31-i]};
            if (w >= {1'b0, divisor_i}) begin
              w = w - {1'b0, divisor_i};
            end
            r = w[CFG_W-1:0];
          end
          r_d = r;
          h_d = h_q << MOD_BITS;
          if (step_q == STEP_LAST) begin
            run_d  = 1'b0;
            done_d = 1'b1;
          end
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_B0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    h_q   <= h_d;
    r_q   <= r_d;
  end

  assign done_o   = done_q;
  assign bucket_o = r_q;

endmodule

// ----- hw/rtl/int_key_hash_table_engine.sv -----
`timescale 1ns / 1ps
// Integer-key chained hash table engine.
// Command channel: a request item (kind, key, value, size) is taken at a clock
// edge where start is high and busy is low. One result item follows per request,
// shown on rsp_o for exactly one cycle while result_valid_o is high; the receiver
// cannot hold it off, so it must take it in that cycle.
// Configuration: bucket_count is written over cfg_valid_i/cfg_ready_o; ready is
// high only while the engine is idle and no request is being started in that
// cycle. Reset value is 16 buckets.
// Sequence: the one-at-a-time hash takes one key byte per step, then a finishing
// step, then the remainder by the bucket count, four quotient bits per step.
// The head slot is then read from the registered bucket memory and decided.
// An insert into an occupied bucket takes a free node in S_POP; a remove of a
// head with a chain moves its first node into the head in S_PULL and frees it
// in S_PUSH; a chain walk reads the nodes from the node memory one after another,
// and a removed node is freed in S_PUSH. One request is in flight at a time, and
// the next one is taken in the cycle after the result.
// Reset empties every bucket and fills the free pool with every node; no clearing
// pass is needed, so requests are taken right after reset.
module int_key_hash_table_engine #(
  parameter int MAX_BUCKETS = 64,
  parameter int POOL_NODES  = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ikht_pkg::req_t             req_i,
  output logic                       result_valid_o,
  output ikht_pkg::rsp_t             rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ikht_pkg::CFG_W-1:0] cfg_data_i
);
  import ikht_pkg::*;

  `include "int_key_hash_table_engine_defines.svh"

  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_NODES);
  localparam logic [LW-1:0] POOL_CNT  = LW'(POOL_NODES);
  localparam logic [LW-1:0] LAST_STEP = LW'(POOL_NODES - 1);

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] size;
  } data_t;

  typedef struct packed {
    data_t         data;
    logic [LW-1:0] link;
  } head_t;

  // Memories: bucket heads, and the node pool with its free stack.
  head_t         head_mem [MAX_BUCKETS];
  data_t         node_dat [POOL_NODES];
  logic [LW-1:0] node_lnk [POOL_NODES];
  logic [IW-1:0] node_stk [POOL_NODES];

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  rsp_t              rsp_q, rsp_d;
  logic [BW-1:0]     bucket_q, bucket_d;
  logic [LW-1:0]     fc_q, fc_d;
  logic [LW-1:0]     mark_q, mark_d;
  logic [LW-1:0]     cur_q, cur_d;
  logic [LW-1:0]     prev_q, prev_d;
  logic [LW-1:0]     steps_q, steps_d;
  logic [IW-1:0]     push_q, push_d;
  logic [MAX_BUCKETS-1:0] head_valid_q;
  logic [CFG_W-1:0]  bucket_count_q;

  head_t             head_rd_q;
  data_t             nd_dat_q;
  logic [LW-1:0]     nd_lnk_q;
  logic [IW-1:0]     nd_stk_q;

  logic              head_we;
  head_t             head_wdata;
  logic              hv_set, hv_clr;
  logic [IW-1:0]     node_raddr, node_waddr;
  logic              nd_we_dat, nd_we_lnk, nd_we_stk;
  data_t             nd_wdat;
  logic [LW-1:0]     nd_wlnk;
  logic [IW-1:0]     nd_wstk;

  logic              hash_done;
  logic [CFG_W-1:0]  hash_bucket;
  logic [CFG_W-1:0]  n_eff;
  logic              accept;
  logic [31:0]       key_bits;
  logic              hv, head_key_eq, head_live, walk_hit, next_live;
  logic [LW-1:0]     fc_m1;
  logic [IW-1:0]     pop_node;

  assign accept   = start && (state_q == S_IDLE);
  assign key_bits = $unsigned(req_q.key);

  // Effective divisor: zero counts as one, large values saturate.
  always_comb begin
    n_eff = bucket_count_q;
    if (bucket_count_q == '0) begin
      n_eff = CFG_W'(1);
    end else if (32'(bucket_count_q) > 32'(MAX_BUCKETS)) begin
      n_eff = CFG_W'(MAX_BUCKETS);
    end
  end

  ikht_hash u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .key_i     ($unsigned(req_i.key)),
    .divisor_i (n_eff),
    .done_o    (hash_done),
    .bucket_o  (hash_bucket)
  );

  // Decisions on the head and node words read in the previous cycle.
  assign hv          = head_valid_q[bucket_q];
  assign head_key_eq = (head_rd_q.data.key == key_bits);
  assign head_live   = (head_rd_q.link < NULL_LINK);
  assign walk_hit    = (nd_dat_q.key == key_bits);
  assign next_live   = (nd_lnk_q < NULL_LINK);
  assign fc_m1       = fc_q - LW'(1);
  assign pop_node    = (fc_m1 < mark_q) ? IW'(fc_m1) : nd_stk_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_d = S_RDHEAD;
        end
      end
      S_RDHEAD: begin
        state_d = S_HEAD;
      end
      S_HEAD: begin
        state_d = S_DONE;
        case (req_q.kind)
          KIND_INSERT: begin
            if (req_q.entry_value != '0 && hv && fc_q != '0) begin
              state_d = S_POP;
            end
          end
          KIND_LOOKUP, KIND_REMOVE: begin
            if (hv && head_key_eq) begin
              if (req_q.kind == KIND_REMOVE && head_live) begin
                state_d = S_PULL;
              end
            end else if (hv && head_live) begin
              state_d = S_WALK;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_POP: begin
        state_d = S_DONE;
      end
      S_PULL: begin
        state_d = S_PUSH;
      end
      S_WALK: begin
        if (walk_hit) begin
          state_d = (req_q.kind == KIND_REMOVE) ? S_PUSH : S_DONE;
        end else if (next_live && steps_q != LAST_STEP) begin
          state_d = S_WALK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PUSH: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath actions and memory accesses of each state.
  always_comb begin
    req_d      = req_q;
    rsp_d      = rsp_q;
    bucket_d   = bucket_q;
    fc_d       = fc_q;
    mark_d     = mark_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    steps_d    = steps_q;
    push_d     = push_q;
    head_we    = 1'b0;
    head_wdata = head_rd_q;
    hv_set     = 1'b0;
    hv_clr     = 1'b0;
    node_raddr = IW'(nd_lnk_q);
    node_waddr = IW'(cur_q);
    nd_we_dat  = 1'b0;
    nd_we_lnk  = 1'b0;
    nd_we_stk  = 1'b0;
    nd_wdat    = '{key: key_bits, value: req_q.entry_value, size: req_q.entry_size};
    nd_wlnk    = head_rd_q.link;
    nd_wstk    = push_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bucket_d = BW'(hash_bucket);
        end
      end
      S_HEAD: begin
        rsp_d = '{status: ST_FAIL, found_value: '0, found_size: '0};
        case (req_q.kind)
          KIND_INSERT: begin
            if (req_q.entry_value != '0) begin
              if (!hv) begin
                head_we    = 1'b1;
                head_wdata = '{data: nd_wdat, link: NULL_LINK};
                hv_set     = 1'b1;
                rsp_d.status = ST_OK;
              end else if (fc_q != '0) begin
                node_raddr = IW'(fc_m1);
              end
            end
          end
          KIND_LOOKUP, KIND_REMOVE: begin
            rsp_d.status = ST_NOT_FOUND;
            node_raddr   = IW'(head_rd_q.link);
            if (hv && head_key_eq) begin
              rsp_d = '{status: ST_OK, found_value: head_rd_q.data.value,
                        found_size: head_rd_q.data.size};
              if (req_q.kind == KIND_REMOVE && !head_live) begin
                hv_clr = 1'b1;
              end
            end else if (hv && head_live) begin
              cur_d   = head_rd_q.link;
              prev_d  = NULL_LINK;
              steps_d = '0;
            end
          end
          default: begin
            rsp_d.status = ST_FAIL;
          end
        endcase
      end
      S_POP: begin
        // Take a node from the free stack and link it right after the head.
        node_waddr = pop_node;
        nd_we_dat  = 1'b1;
        nd_we_lnk  = 1'b1;
        head_we    = 1'b1;
        head_wdata.link = LW'(pop_node);
        fc_d = fc_m1;
        if (fc_m1 < mark_q) begin
          mark_d = fc_m1;
        end
        rsp_d.status = ST_OK;
      end
      S_PULL: begin
        // The first chain node moves into the head and is freed.
        head_we    = 1'b1;
        head_wdata = '{data: nd_dat_q, link: nd_lnk_q};
        push_d     = IW'(head_rd_q.link);
      end
      S_WALK: begin
        if (walk_hit) begin
          rsp_d = '{status: ST_OK, found_value: nd_dat_q.value, found_size: nd_dat_q.size};
          if (req_q.kind == KIND_REMOVE) begin
            push_d = IW'(cur_q);
            if (prev_q < NULL_LINK) begin
              node_waddr = IW'(prev_q);
              nd_we_lnk  = 1'b1;
              nd_wlnk    = nd_lnk_q;
            end else begin
              head_we         = 1'b1;
              head_wdata.link = nd_lnk_q;
            end
          end
        end else if (next_live && steps_q != LAST_STEP) begin
          prev_d  = cur_q;
          cur_d   = nd_lnk_q;
          steps_d = steps_q + LW'(1);
        end
      end
      S_PUSH: begin
        if (fc_q < POOL_CNT) begin
          node_waddr = IW'(fc_q);
          nd_we_stk  = 1'b1;
          fc_d       = fc_q + LW'(1);
        end
      end
      default: begin
        rsp_d = rsp_q;
      end
    endcase
  end

  // Outputs. The bucket count is not written in the cycle a request is taken,
  // since the hash of that request divides by it.
  always_comb begin
    busy           = (state_q != S_IDLE);
    cfg_ready_o    = (state_q == S_IDLE) && !start;
    result_valid_o = (state_q == S_DONE);
    rsp_o          = rsp_q;
  end

  // Bucket head memory: one read and one write port at the current bucket.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[bucket_q] <= head_wdata;
    end
    head_rd_q <= head_mem[bucket_q];
  end

  // Node pool memory with its free stack: one read and one write address.
  always_ff @(posedge clk_i) begin
    if (nd_we_dat) begin
      node_dat[node_waddr] <= nd_wdat;
    end
    if (nd_we_lnk) begin
      node_lnk[node_waddr] <= nd_wlnk;
    end
    if (nd_we_stk) begin
      node_stk[node_waddr] <= nd_wstk;
    end
    nd_dat_q <= node_dat[node_raddr];
    nd_lnk_q <= node_lnk[node_raddr];
    nd_stk_q <= node_stk[node_raddr];
  end

  // Control registers. Free stack slots below the low-water mark were never
  // written and read as their own index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      fc_q           <= POOL_CNT;
      mark_q         <= POOL_CNT;
      head_valid_q   <= '0;
      bucket_count_q <= BUCKET_RESET;
    end else begin
      state_q <= state_d;
      fc_q    <= fc_d;
      mark_q  <= mark_d;
      if (hv_set) begin
        head_valid_q[bucket_q] <= 1'b1;
      end else if (hv_clr) begin
        head_valid_q[bucket_q] <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        bucket_count_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rsp_q    <= rsp_d;
    bucket_q <= bucket_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    steps_q  <= steps_d;
    push_q   <= push_d;
  end

  `IKHT_ASSERT(a_fc_range, clk_i, rst_ni, fc_q <= POOL_CNT, "free count above pool size")
  `IKHT_ASSERT(a_mark_le_fc, clk_i, rst_ni, mark_q <= fc_q, "low-water mark above free count")
  `IKHT_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy, "accepted item left engine idle")
  `IKHT_ASSERT(a_single_result, clk_i, rst_ni, result_valid_o |=> !result_valid_o, "result strobe held")
  `IKHT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !result_valid_o, "result during reset")

endmodule

// ----- bench/int_key_hash_table_engine_checker.sv -----
`timescale 1ns / 1ps
module int_key_hash_table_engine_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  ikht_pkg::req_t             req_i,
  input  logic                       result_valid_i,
  input  ikht_pkg::rsp_t             rsp_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [ikht_pkg::CFG_W-1:0] cfg_data_i,
  output int                         mismatch_count_o,
  output int                         pending_o
);
  import ikht_pkg::*;

  localparam int BUCKET_SLOTS = 64;
  localparam int NUM_NODES    = 64;
  localparam int NO_LINK      = NUM_NODES;

  // Mirror of the table contents and the bucket count register.
  logic [CFG_W-1:0] bucket_reg;
  logic             slot_used [BUCKET_SLOTS];
  logic [31:0]      slot_key  [BUCKET_SLOTS];
  logic [31:0]      slot_val  [BUCKET_SLOTS];
  logic [31:0]      slot_size [BUCKET_SLOTS];
  int               slot_next [BUCKET_SLOTS];
  logic [31:0]      node_key  [NUM_NODES];
  logic [31:0]      node_val  [NUM_NODES];
  logic [31:0]      node_size [NUM_NODES];
  int               node_next [NUM_NODES];
  int               spare_nodes [NUM_NODES];
  int               spare_count;

  // Results still owed by the block, oldest first.
  rsp_t owed_results[$];

  assign pending_o = owed_results.size();

  // One line per mismatch, and the count goes up.
  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatch_count_o++;
  endtask

  // One-at-a-time hash over the key bytes, low byte first.
  function automatic logic [31:0] oaat(input logic [31:0] k);
    logic [31:0] h;
    h = '0;
    for (int i = 0; i < 4; i++) begin
      h = h + ((k >> (8 * i)) & 32'hFF);
      h = h + (h << HASH_SHL_ADD);
      h = h ^ (h >> HASH_SHR_XOR);
    end
    h = h + (h << FIN_SHL_A);
    h = h ^ (h >> FIN_SHR);
    h = h + (h << FIN_SHL_B);
    return h;
  endfunction

  function automatic void release_node(input int idx);
    if (idx < NUM_NODES && spare_count < NUM_NODES) begin
      spare_nodes[spare_count] = idx;
      spare_count++;
    end
  endfunction

  // Applies one request to the mirror and returns the result it should give.
  function automatic rsp_t table_access(input req_t rq);
    rsp_t        r;
    int          n;
    int          b;
    int          nd;
    int          prev;
    int          cur;
    int          steps;
    logic [31:0] k;
    r = '{status: ST_FAIL, found_value: '0, found_size: '0};
    k = rq.key;
    n = int'(bucket_reg);
    if (n == 0) n = 1;
    if (n > BUCKET_SLOTS) n = BUCKET_SLOTS;
    b = int'(oaat(k) % n);
    if (rq.kind == KIND_INSERT) begin
      if (rq.entry_value != 0) begin
        if (!slot_used[b]) begin
          slot_used[b] = 1'b1;
          slot_key[b]  = k;
          slot_val[b]  = rq.entry_value;
          slot_size[b] = rq.entry_size;
          slot_next[b] = NO_LINK;
          r.status = ST_OK;
        end else if (spare_count > 0) begin
          spare_count--;
          nd = spare_nodes[spare_count];
          node_key[nd]  = k;
          node_val[nd]  = rq.entry_value;
          node_size[nd] = rq.entry_size;
          node_next[nd] = slot_next[b];
          slot_next[b]  = nd;
          r.status = ST_OK;
        end
      end
    end else if (rq.kind == KIND_LOOKUP || rq.kind == KIND_REMOVE) begin
      r.status = ST_NOT_FOUND;
      if (slot_used[b]) begin
        if (slot_key[b] == k) begin
          r = '{status: ST_OK, found_value: slot_val[b], found_size: slot_size[b]};
          if (rq.kind == KIND_REMOVE) begin
            nd = slot_next[b];
            // A removed head takes over its first chain node.
            if (nd < NUM_NODES) begin
              slot_key[b]  = node_key[nd];
              slot_val[b]  = node_val[nd];
              slot_size[b] = node_size[nd];
              slot_next[b] = node_next[nd];
              release_node(nd);
            end else begin
              slot_used[b] = 1'b0;
              slot_next[b] = NO_LINK;
            end
          end
        end else begin
          prev  = NO_LINK;
          cur   = slot_next[b];
          steps = 0;
          while (cur < NUM_NODES && steps < NUM_NODES) begin
            if (node_key[cur] == k) begin
              r = '{status: ST_OK, found_value: node_val[cur], found_size: node_size[cur]};
              if (rq.kind == KIND_REMOVE) begin
                if (prev < NUM_NODES) node_next[prev] = node_next[cur];
                else slot_next[b] = node_next[cur];
                node_next[cur] = NO_LINK;
                release_node(cur);
              end
              break;
            end
            prev = cur;
            cur  = node_next[cur];
            steps++;
          end
        end
      end
    end
    return r;
  endfunction

  // Watch the three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      bucket_reg  = BUCKET_RESET;
      spare_count = NUM_NODES;
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_next[i] = NO_LINK;
      end
      for (int i = 0; i < NUM_NODES; i++) begin
        node_next[i]   = NO_LINK;
        spare_nodes[i] = i;
      end
      owed_results.delete();
    end else begin
      if (result_valid_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = owed_results.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp_i.status, want.status));
          if (rsp_i.found_value !== want.found_value)
            report_mismatch($sformatf("found_value %h, expected %h",
                                      rsp_i.found_value, want.found_value));
          if (rsp_i.found_size !== want.found_size)
            report_mismatch($sformatf("found_size %h, expected %h",
                                      rsp_i.found_size, want.found_size));
        end
      end
      if (start_i && !busy_i) owed_results.push_back(table_access(req_i));
      if (cfg_valid_i && cfg_ready_i) bucket_reg = cfg_data_i;
    end
  end

  initial mismatch_count_o = 0;

endmodule

// ----- bench/int_key_hash_table_engine_test.sv -----
`timescale 1ns / 1ps
module int_key_hash_table_engine_test;
  import ikht_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 128;
  localparam int QUIET_CYCLES = 150;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             req = '0;
  logic             result_valid;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  int               mismatches;
  int               owed;
  logic [31:0]      key_set[$];
  int               idle_pct;

  int_key_hash_table_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid),
    .rsp_o          (rsp),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  int_key_hash_table_engine_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req),
    .result_valid_i   (result_valid),
    .rsp_i            (rsp),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (owed)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Drives one item and waits for it to be taken; busy seen at a falling
  // edge is what the next rising edge samples.
  task automatic issue(input req_t rq);
    int gap;
    start <= 1'b1;
    req   <= rq;
    do @(negedge clk_i); while (busy);
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Lets all owed results drain, then writes the bucket count once.
  task automatic set_buckets(input logic [CFG_W-1:0] count);
    start <= 1'b0;
    @(negedge clk_i);
    wait (owed == 0);
    repeat (QUIET_CYCLES) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(negedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic req_t make(input logic [1:0] kind, input logic [31:0] key,
                                input logic [31:0] val, input logic [31:0] size);
    req_t rq;
    rq.kind = kind;
    rq.key = key;
    rq.entry_value = val;
    rq.entry_size = size;
    return rq;
  endfunction

  // Random request, mostly on a small set of keys so entries get hit again.
  function automatic req_t random_request();
    req_t        rq;
    int          pick;
    logic [31:0] v;
    pick = $urandom_range(99);
    rq.kind = pick < 48 ? KIND_INSERT : pick < 75 ? KIND_LOOKUP :
              pick < 97 ? KIND_REMOVE : KIND_UNUSED;
    rq.key = ($urandom_range(99) < 75) ? key_set[$urandom_range(key_set.size() - 1)]
                                       : $urandom;
    v = $urandom;
    rq.entry_value = ($urandom_range(99) < 8) ? 32'd0 : v;
    rq.entry_size = $urandom;
    return rq;
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_count [6];
    int               phase_idle  [6];
    phase_count = '{7'd16, 7'd1, 7'd64, 7'd0, 7'd127, 7'd5};
    phase_idle  = '{0, 77, 11, 0, 77, 11};
    idle_pct = 0;
    key_set = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h100};
    repeat (18) key_set.push_back($urandom);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items: field extremes, every kind, and the named corner cases.
    issue(make(KIND_INSERT, 32'h0, 32'h1, 32'h0));
    issue(make(KIND_INSERT, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    issue(make(KIND_INSERT, 32'h80000000, 32'h0, 32'h1234));
    issue(make(KIND_LOOKUP, 32'h80000000, 32'h0, 32'h0));
    issue(make(KIND_LOOKUP, 32'h7FFFFFFF, 32'h0, 32'h0));
    issue(make(KIND_INSERT, 32'h0, 32'hAAAA5555, 32'h5555AAAA));
    issue(make(KIND_LOOKUP, 32'h0, 32'h0, 32'h0));
    issue(make(KIND_UNUSED, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF));
    issue(make(KIND_REMOVE, 32'h0, 32'h0, 32'h0));
    issue(make(KIND_LOOKUP, 32'h0, 32'h0, 32'h0));
    issue(make(KIND_REMOVE, 32'h0, 32'h0, 32'h0));
    issue(make(KIND_REMOVE, 32'h0, 32'h0, 32'h0));
    issue(make(KIND_REMOVE, 32'hFFFFFFFF, 32'h0, 32'h0));

    // One bucket only: long chains, removal from the middle, then pool exhaustion.
    set_buckets(7'd1);
    for (int i = 0; i < 3; i++) issue(make(KIND_INSERT, 32'h10 + i, 32'h100 + i, i));
    issue(make(KIND_REMOVE, 32'h11, 32'h0, 32'h0));
    issue(make(KIND_LOOKUP, 32'h10, 32'h0, 32'h0));
    issue(make(KIND_REMOVE, 32'h7FFFFFFF, 32'h0, 32'h0));
    for (int i = 0; i < 66; i++) issue(make(KIND_INSERT, $urandom, $urandom | 32'h1, $urandom));
    issue(make(KIND_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'h0));

    // Random phases across bucket counts and sender idling.
    for (int p = 0; p < 6; p++) begin
      set_buckets(p == 5 ? 7'($urandom_range(2, 63)) : phase_count[p]);
      idle_pct = phase_idle[p];
      for (int i = 0; i < PHASE_ITEMS; i++) issue(random_request());
    end

    start <= 1'b0;
    wait (owed == 0);
    repeat (QUIET_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && owed == 0) begin
      $display("** int_key_hash_table_engine: PASSED **");
    end else begin
      $display("** int_key_hash_table_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** int_key_hash_table_engine: FAILED **");
    $finish;
  end

endmodule
